[sv/assert_macros.svh]
// assertion macros used by the checker file gis_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/gis_pkg.sv]
// types, sizes and codes of the graph incidence store
`timescale 1ns / 1ps
package gis_pkg;
	localparam int MAX_NODES  = 32;
	localparam int MAX_DEGREE = 16;
	localparam int ID_WIDTH   = 16;

	localparam int SW    = $clog2(MAX_NODES);
	localparam int SC_W  = $clog2(MAX_NODES + 1);
	localparam int DEG_W = $clog2(MAX_DEGREE + 1);
	localparam int IA_W  = $clog2(MAX_NODES * MAX_DEGREE);
	localparam int CMD_W = 3;
	localparam int ST_W  = 3;
	localparam int DOUT_W = 5;

	localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_NODE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_EDGE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_NODE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SRCH_NODE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SRCH_EDGE = 3'd5;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_NO_NODE = 3'd1;
	localparam logic [ST_W-1:0] ST_PRESENT = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
	localparam logic [ST_W-1:0] ST_NO_EDGE = 3'd4;

	typedef struct packed {
		logic [ID_WIDTH-1:0] ident;
		logic [DEG_W-1:0]    deg;
	} node_ent_t;

	// flat address of list entry k of a slot
	function automatic logic [IA_W-1:0] inc_addr(input logic [SW-1:0] slot,
		input logic [DEG_W-1:0] k);
		inc_addr = IA_W'(IA_W'(slot) * IA_W'(MAX_DEGREE) + IA_W'(k));
	endfunction
endpackage

[sv/graph_incidence_store.sv]
// Undirected graph store: node table plus per-node incidence lists.
// Input channel in_valid/in_ready carries one command beat (cmd, node_a,
// node_b, edge_id). Output channel out_valid/out_ready returns one beat
// (status, degree) per command, in order.
// One command is worked at a time; in_ready is high only while idle.
// Run time is set by walks over the node table and list ram: a live entry
// is read, then compared; an empty one is skipped on its valid bit.
//   Create writes its node directly; a node lookup walks the node table,
//   then dispatch and the output register follow. Insert edge does two
//   lookups plus two appends; search edge a lookup plus a walk of the list
//   of node_a; delete node a lookup plus, per edge of the node, a pass
//   over all other nodes and their lists.
// Results sit in an output register; the next command is taken as soon as
// a result has moved into it. A stalled receiver holds the beat there, and
// the following result waits in the block until the beat leaves.
// Reset empties the graph at once (valid bits cleared); memory contents
// need no clearing pass.
`timescale 1ns / 1ps
module graph_incidence_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gis_pkg::CMD_W-1:0]      cmd,
	input  logic [gis_pkg::ID_WIDTH-1:0]   node_a,
	input  logic [gis_pkg::ID_WIDTH-1:0]   node_b,
	input  logic [gis_pkg::ID_WIDTH-1:0]   edge_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gis_pkg::ST_W-1:0]       status,
	output logic [gis_pkg::DOUT_W-1:0]     degree
);
	import gis_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CREATE, S_FA_RD, S_FA_CK, S_FB_RD, S_FB_CK, S_EXEC,
		S_APP1, S_APP2, S_DK_RD, S_DK_CK, S_DI, S_DI_CK, S_DJ_RD, S_DJ_CK,
		S_SH_RD, S_SH_WR, S_SE_RD, S_SE_CK, S_DONE
	} state_t;

	state_t state_q;

	logic [CMD_W-1:0]     cmd_q;
	logic [ID_WIDTH-1:0]  a_q, b_q, e_q, ed_q, tid_q;
	logic [MAX_NODES-1:0] valid_q;
	logic [SC_W-1:0]      i_q;
	logic [SW-1:0]        sa_q, sb_q, free_q;
	logic                 fa_q, fb_q, free_ok_q;
	logic [DEG_W-1:0]     dega_q, degb_q, k_q, j_q, m_q, n_q;
	logic [ST_W-1:0]      res_st_q;
	logic [DEG_W-1:0]     res_deg_q;
	logic                 out_valid_q;
	logic [ST_W-1:0]      status_q;
	logic [DEG_W-1:0]     degree_q;

	logic                 tbl_we;
	logic [SW-1:0]        tbl_waddr, tbl_raddr;
	node_ent_t            tbl_wdata, tbl_rdata;
	logic                 inc_we;
	logic [IA_W-1:0]      inc_waddr, inc_raddr;
	logic [ID_WIDTH-1:0]  inc_wdata, inc_rdata;

	logic [SW-1:0]        slot_i;
	logic                 scan_end;
	logic                 self_loop;
	logic [DEG_W:0]       a_plus1, a_plus2, b_plus1;
	logic [DEG_W:0]       max_deg;

	assign slot_i    = i_q[SW-1:0];
	assign scan_end  = (i_q == SC_W'(MAX_NODES));
	assign self_loop = (sa_q == sb_q);
	assign a_plus1   = {1'b0, dega_q} + (DEG_W+1)'(1);
	assign a_plus2   = {1'b0, dega_q} + (DEG_W+1)'(2);
	assign b_plus1   = {1'b0, degb_q} + (DEG_W+1)'(1);
	assign max_deg   = (DEG_W+1)'(MAX_DEGREE);

	gis_ram #(.WIDTH($bits(node_ent_t)), .DEPTH(MAX_NODES)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	gis_ram #(.WIDTH(ID_WIDTH), .DEPTH(MAX_NODES * MAX_DEGREE)) u_inc (
		.clk(clk), .we(inc_we), .waddr(inc_waddr), .wdata(inc_wdata),
		.raddr(inc_raddr), .rdata(inc_rdata)
	);

	// memory port control per state
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = '0;
		tbl_wdata = '0;
		tbl_raddr = slot_i;
		inc_we    = 1'b0;
		inc_waddr = '0;
		inc_wdata = e_q;
		inc_raddr = '0;
		case (state_q)
			S_CREATE: begin
				tbl_we    = 1'b1;
				tbl_wdata = '{ident: a_q, deg: '0};
			end
			S_EXEC: begin
				if (cmd_q == CMD_INS_NODE && !fa_q && free_ok_q) begin
					tbl_we    = 1'b1;
					tbl_waddr = free_q;
					tbl_wdata = '{ident: a_q, deg: '0};
				end
			end
			S_APP1: begin
				inc_we    = 1'b1;
				inc_waddr = inc_addr(sa_q, dega_q);
				tbl_we    = 1'b1;
				tbl_waddr = sa_q;
				tbl_wdata = '{ident: a_q, deg: a_plus1[DEG_W-1:0]};
			end
			S_APP2: begin
				inc_we = 1'b1;
				tbl_we = 1'b1;
				if (self_loop) begin
					inc_waddr = inc_addr(sa_q, a_plus1[DEG_W-1:0]);
					tbl_waddr = sa_q;
					tbl_wdata = '{ident: a_q, deg: a_plus2[DEG_W-1:0]};
				end else begin
					inc_waddr = inc_addr(sb_q, degb_q);
					tbl_waddr = sb_q;
					tbl_wdata = '{ident: b_q, deg: b_plus1[DEG_W-1:0]};
				end
			end
			S_DK_RD: inc_raddr = inc_addr(sa_q, k_q);
			S_DJ_RD: inc_raddr = inc_addr(slot_i, j_q);
			S_SH_RD: begin
				inc_raddr = inc_addr(slot_i, m_q + 1'b1);
				if (m_q + 1'b1 == n_q) begin
					tbl_we    = 1'b1;
					tbl_waddr = slot_i;
					tbl_wdata = '{ident: tid_q, deg: n_q - 1'b1};
				end
			end
			S_SH_WR: begin
				inc_we    = 1'b1;
				inc_waddr = inc_addr(slot_i, m_q);
				inc_wdata = inc_rdata;
			end
			S_SE_RD: inc_raddr = inc_addr(sa_q, j_q);
			default: ;
		endcase
	end

	// command sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			m_q         <= '0;
			fa_q        <= 1'b0;
			fb_q        <= 1'b0;
			free_ok_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q     <= cmd;
						a_q       <= node_a;
						b_q       <= node_b;
						e_q       <= edge_id;
						i_q       <= '0;
						fa_q      <= 1'b0;
						fb_q      <= 1'b0;
						free_ok_q <= 1'b0;
						state_q   <= (cmd == CMD_CREATE) ? S_CREATE : S_FA_RD;
					end
				end
				S_CREATE: begin
					valid_q   <= MAX_NODES'(1);
					res_st_q  <= ST_OK;
					res_deg_q <= '0;
					state_q   <= S_DONE;
				end
				// lookup of node_a, noting the first free slot
				S_FA_RD: begin
					if (scan_end) begin
						i_q     <= '0;
						state_q <= (cmd_q == CMD_INS_EDGE) ? S_FB_RD : S_EXEC;
					end else if (!valid_q[slot_i]) begin
						if (!free_ok_q) begin
							free_q    <= slot_i;
							free_ok_q <= 1'b1;
						end
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= S_FA_CK;
					end
				end
				S_FA_CK: begin
					if (tbl_rdata.ident == a_q) begin
						fa_q    <= 1'b1;
						sa_q    <= slot_i;
						dega_q  <= tbl_rdata.deg;
						i_q     <= '0;
						state_q <= (cmd_q == CMD_INS_EDGE) ? S_FB_RD : S_EXEC;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_FA_RD;
					end
				end
				// lookup of node_b
				S_FB_RD: begin
					if (scan_end) begin
						state_q <= S_EXEC;
					end else if (!valid_q[slot_i]) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= S_FB_CK;
					end
				end
				S_FB_CK: begin
					if (tbl_rdata.ident == b_q) begin
						fb_q    <= 1'b1;
						sb_q    <= slot_i;
						degb_q  <= tbl_rdata.deg;
						state_q <= S_EXEC;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_FB_RD;
					end
				end
				// dispatch on command once lookups are in
				S_EXEC: begin
					res_deg_q <= fa_q ? dega_q : '0;
					case (cmd_q)
						CMD_INS_NODE: begin
							if (fa_q) begin
								res_st_q <= ST_PRESENT;
							end else if (!free_ok_q) begin
								res_st_q <= ST_FULL;
							end else begin
								res_st_q        <= ST_OK;
								valid_q[free_q] <= 1'b1;
							end
							state_q <= S_DONE;
						end
						CMD_INS_EDGE: begin
							if (!(fa_q && fb_q)) begin
								res_st_q <= ST_NO_NODE;
								state_q  <= S_DONE;
							end else if (self_loop ? (a_plus2 > max_deg)
								: (a_plus1 > max_deg || b_plus1 > max_deg)) begin
								res_st_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_APP1;
							end
						end
						CMD_DEL_NODE: begin
							if (!fa_q) begin
								res_st_q <= ST_NO_NODE;
								state_q  <= S_DONE;
							end else begin
								k_q     <= '0;
								state_q <= S_DK_RD;
							end
						end
						CMD_SRCH_NODE: begin
							res_st_q <= fa_q ? ST_OK : ST_NO_NODE;
							state_q  <= S_DONE;
						end
						CMD_SRCH_EDGE: begin
							if (!fa_q) begin
								res_st_q <= ST_NO_NODE;
								state_q  <= S_DONE;
							end else begin
								j_q     <= '0;
								state_q <= S_SE_RD;
							end
						end
						default: begin
							res_st_q <= ST_OK;
							state_q  <= S_DONE;
						end
					endcase
				end
				S_APP1: state_q <= S_APP2;
				S_APP2: begin
					res_st_q  <= ST_OK;
					res_deg_q <= self_loop ? a_plus2[DEG_W-1:0] : a_plus1[DEG_W-1:0];
					state_q   <= S_DONE;
				end
				// delete: walk the target list one edge at a time
				S_DK_RD: begin
					if (k_q == dega_q) begin
						valid_q[sa_q] <= 1'b0;
						res_st_q      <= ST_OK;
						res_deg_q     <= '0;
						state_q       <= S_DONE;
					end else begin
						state_q <= S_DK_CK;
					end
				end
				S_DK_CK: begin
					ed_q    <= inc_rdata;
					i_q     <= '0;
					state_q <= S_DI;
				end
				// visit every other valid node
				S_DI: begin
					if (scan_end) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_DK_RD;
					end else if (slot_i == sa_q || !valid_q[slot_i]) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= S_DI_CK;
					end
				end
				S_DI_CK: begin
					n_q     <= tbl_rdata.deg;
					tid_q   <= tbl_rdata.ident;
					j_q     <= '0;
					state_q <= S_DJ_RD;
				end
				// look for the first match in that node's list
				S_DJ_RD: begin
					if (j_q == n_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_DI;
					end else begin
						state_q <= S_DJ_CK;
					end
				end
				S_DJ_CK: begin
					if (inc_rdata == ed_q) begin
						m_q     <= j_q;
						state_q <= S_SH_RD;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_DJ_RD;
					end
				end
				// close the gap by moving the tail down one entry
				S_SH_RD: begin
					if (m_q + 1'b1 == n_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_DI;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					m_q     <= m_q + 1'b1;
					state_q <= S_SH_RD;
				end
				// search edge in node_a list
				S_SE_RD: begin
					if (j_q == dega_q) begin
						res_st_q <= ST_NO_EDGE;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_SE_CK;
					end
				end
				S_SE_CK: begin
					if (inc_rdata == e_q) begin
						res_st_q <= ST_OK;
						state_q  <= S_DONE;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_SE_RD;
					end
				end
				// hand the result beat to the output register
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_st_q;
						degree_q    <= res_deg_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign degree    = DOUT_W'(degree_q);
endmodule

[sv/gis_ram.sv]
// simple dual port ram with registered read data
`timescale 1ns / 1ps
module gis_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

[sv/gis_checker.sv]
// port-level checks of the graph incidence store, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gis_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [gis_pkg::ST_W-1:0]     status,
	input logic [gis_pkg::DOUT_W-1:0]   degree
);
	import gis_pkg::*;

	// stalled result beat holds its payload
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(degree))
	// only defined status codes leave the block
	`ASSERT_IMPL(a_status_legal, clk, arst_n, out_valid, status == ST_OK || status == ST_NO_NODE || status == ST_PRESENT || status == ST_FULL || status == ST_NO_EDGE)
	// a reported degree never exceeds the list size
	`ASSERT_IMPL(a_deg_bound, clk, arst_n, out_valid, degree <= DOUT_W'(MAX_DEGREE))
	// a command is never answered in the cycle right after it is taken
	`ASSERT_NEXT(a_min_latency, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid)
endmodule

bind graph_incidence_store gis_checker u_gis_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status), .degree(degree)
);
